// ===== src/vtm_pkg.sv =====
// Shared constants, types and the arctangent table for the view matrix generator.
// Used by vtm_cordic_cell, vtm_div_cell and view_transform_matrix_gen.
`default_nettype none
package vtm_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int STG_W = 5;
	localparam int XW = 34;
	localparam int ZW = 34;
	localparam int AW = 33;
	localparam int NW = 64;
	localparam int DW = 37;
	localparam int QW = 40;
	localparam int HW = NW - QW;
	localparam int LANES = 6;

	localparam logic signed [AW-1:0] TWO_PI_Q28  = 33'sd1686629713;
	localparam logic signed [AW-1:0] PI_Q28      = 33'sd843314857;
	localparam logic signed [AW-1:0] HALF_PI_Q28 = 33'sd421657428;
	localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

	localparam logic [QW-1:0] OUT_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] OUT_MIN = {1'b1, {(QW-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [XW-1:0] y;
		logic [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [DW-1:0] r;
		logic [QW-1:0] nq;
		logic [DW-1:0] d;
		logic          negr;
		logic          ovf;
	} div_lane_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [STG_W-1:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			5'd0:  v = 34'sh03243F6A8;
			5'd1:  v = 34'sh01DAC6705;
			5'd2:  v = 34'sh00FADBAFC;
			5'd3:  v = 34'sh007F56EA6;
			5'd4:  v = 34'sh003FEAB76;
			5'd5:  v = 34'sh001FFD55B;
			5'd6:  v = 34'sh000FFFAAA;
			5'd7:  v = 34'sh0007FFF55;
			5'd8:  v = 34'sh0003FFFEA;
			5'd9:  v = 34'sh0001FFFFD;
			5'd10: v = 34'sh0000FFFFF;
			5'd11: v = 34'sh00007FFFF;
			5'd12: v = 34'sh00003FFFF;
			5'd13: v = 34'sh00001FFFF;
			5'd14: v = 34'sh00000FFFF;
			5'd15: v = 34'sh000007FFF;
			5'd16: v = 34'sh000003FFF;
			5'd17: v = 34'sh000001FFF;
			5'd18: v = 34'sh000000FFF;
			5'd19: v = 34'sh0000007FF;
			5'd20: v = 34'sh0000003FF;
			5'd21: v = 34'sh0000001FF;
			5'd22: v = 34'sh0000000FF;
			5'd23: v = 34'sh00000007F;
			5'd24: v = 34'sh00000003F;
			5'd25: v = 34'sh00000001F;
			5'd26: v = 34'sh00000000F;
			5'd27: v = 34'sh000000008;
			5'd28: v = 34'sh000000004;
			5'd29: v = 34'sh000000002;
			5'd30: v = 34'sh000000001;
			5'd31: v = 34'sh000000000;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== src/vtm_cordic_cell.sv =====
// One rotation-mode CORDIC iteration with its output register.
// Depends on vtm_pkg.
`default_nettype none
module vtm_cordic_cell (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [vtm_pkg::STG_W-1:0]  stage,
	input  wire vtm_pkg::cordic_t           din,
	output vtm_pkg::cordic_t                dout
);
	import vtm_pkg::*;

	logic signed [XW-1:0] xi, yi, dx, dy;
	logic signed [ZW-1:0] zi, at;
	cordic_t nxt, cell_q;

	always_comb begin
		xi = din.x;
		yi = din.y;
		zi = din.z;
		dx = yi >>> stage;
		dy = xi >>> stage;
		at = atan_q30(stage);
		if (!zi[ZW-1]) begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = zi - at;
		end else begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = zi + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule
`default_nettype wire

// ===== src/vtm_div_cell.sv =====
// One restoring-division step: one quotient bit per cell, registered.
// Depends on vtm_pkg.
`default_nettype none
module vtm_div_cell (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire vtm_pkg::div_lane_t din,
	output vtm_pkg::div_lane_t      dout
);
	import vtm_pkg::*;

	logic [DW:0] t, diff;
	logic        ge;
	div_lane_t   nxt, cell_q;

	always_comb begin
		t    = {din.r, din.nq[QW-1]};
		diff = t - {1'b0, din.d};
		ge   = (t >= {1'b0, din.d});
		nxt      = din;
		nxt.r    = ge ? diff[DW-1:0] : t[DW-1:0];
		nxt.nq   = {din.nq[QW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule
`default_nettype wire

// ===== src/view_transform_matrix_gen.sv =====
// Top level: 2D view matrix generator, angle reduction, CORDIC row, products,
// six rows of divider cells and output register. Depends on vtm_pkg and both cells.
//
// Usage:
//  Input stream s_*: one view per transfer, s_tdata = center_x, center_y,
//  extent_x, extent_y, angle (32 bit each, lowest first).
//  Output stream m_*: one matrix per transfer, m_tdata = m00 m01 m02 m10 m11 m12
//  (40 bit each, lowest first), m_tuser = status.
//  Pipeline: 2 + CORDIC_STAGES + 6 + 40 + 1 register stages (73 at 24 stages), set by
//  the CORDIC cell row and the 40-cell divider rows.
//  Throughput: one view per cycle while the output is not stalled; every stage is a register in a single pipeline.
//  Stall: when the output holds an untaken matrix, the whole pipeline freezes
//  and s_tready drops; nothing is lost or repeated.
//  Reset: arst_n clears all valid bits; data registers are not reset.
//  A zero width or height returns status 1 with all entries zero.
`default_nettype none
module view_transform_matrix_gen (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [159:0] s_tdata,  // center_x, center_y, extent_x, extent_y, angle
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [239:0]      m_tdata,  // m00, m01, m02, m10, m11, m12
	output logic [1:0]        m_tuser   // status
);
	import vtm_pkg::*;

	localparam int CORD = CORDIC_STAGES;
	localparam int LAT  = 2 + CORD + 6 + QW + 1;

	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] sx;
		logic [31:0] sy;
		logic        neg;
	} view_t;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic [LAT-2:0] zf_q;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	// input unpack and coarse angle reduction
	logic signed [31:0]   in_ang;
	logic signed [AW-1:0] a_ext, a_mod;
	logic                 in_zero;

	always_comb begin
		in_ang  = s_tdata[159:128];
		in_zero = (s_tdata[95:64] == '0) || (s_tdata[127:96] == '0);
		a_ext   = AW'(in_ang);
		if (a_ext >= TWO_PI_Q28) begin
			a_mod = a_ext - TWO_PI_Q28;
		end else if (a_ext <= -TWO_PI_Q28) begin
			a_mod = a_ext + TWO_PI_Q28;
		end else begin
			a_mod = a_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zf_q <= {zf_q[LAT-3:0], in_zero};
		end
	end

	// s1
	view_t                view_s1;
	logic signed [AW-1:0] r_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			view_s1.cx  <= s_tdata[31:0];
			view_s1.cy  <= s_tdata[63:32];
			view_s1.sx  <= s_tdata[95:64];
			view_s1.sy  <= s_tdata[127:96];
			view_s1.neg <= 1'b0;
			r_s1        <= a_mod;
		end
	end

	// s2: range (-pi, pi], fold to +-pi/2
	logic signed [AW-1:0] r_a, r_b;
	logic signed [ZW-1:0] z0;
	logic                 fold;
	view_t                view_s2;
	cordic_t              cord_s2;

	always_comb begin
		if (r_s1 > PI_Q28) begin
			r_a = r_s1 - TWO_PI_Q28;
		end else if (r_s1 <= -PI_Q28) begin
			r_a = r_s1 + TWO_PI_Q28;
		end else begin
			r_a = r_s1;
		end
		if (r_a > HALF_PI_Q28) begin
			r_b  = r_a - PI_Q28;
			fold = 1'b1;
		end else if (r_a < -HALF_PI_Q28) begin
			r_b  = r_a + PI_Q28;
			fold = 1'b1;
		end else begin
			r_b  = r_a;
			fold = 1'b0;
		end
		z0 = ZW'(r_b) <<< 2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			view_s2.cx  <= view_s1.cx;
			view_s2.cy  <= view_s1.cy;
			view_s2.sx  <= view_s1.sx;
			view_s2.sy  <= view_s1.sy;
			view_s2.neg <= fold;
			cord_s2.x   <= GAIN_Q30;
			cord_s2.y   <= '0;
			cord_s2.z   <= z0;
		end
	end

	// CORDIC cell row
	cordic_t cd [0:CORD];
	view_t   vw_q [0:CORD-1];

	assign cd[0] = cord_s2;

	for (genvar k = 0; k < CORD; k++) begin : g_cord
		vtm_cordic_cell u_cell (
			.clk   (clk),
			.en    (adv),
			.stage (STG_W'(k)),
			.din   (cd[k]),
			.dout  (cd[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vw_q[0] <= view_s2;
			for (int k = 1; k < CORD; k++) begin
				vw_q[k] <= vw_q[k-1];
			end
		end
	end

	// s3: sign fix of sine and cosine
	logic signed [XW-1:0] xo, yo, c_s3, s_s3;
	view_t                view_s3;

	always_comb begin
		xo = cd[CORD].x;
		yo = cd[CORD].y;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3    <= vw_q[CORD-1].neg ? -xo : xo;
			s_s3    <= vw_q[CORD-1].neg ? -yo : yo;
			view_s3 <= vw_q[CORD-1];
		end
	end

	// s4: products
	logic signed [31:0]   cx3, cy3;
	logic signed [NW-1:0] pxc_s4, pys_s4, pxs_s4, pyc_s4, c2k_s4, s2k_s4;
	logic signed [31:0]   sx_s4, sy_s4;

	always_comb begin
		cx3 = view_s3.cx;
		cy3 = view_s3.cy;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxc_s4 <= cx3 * c_s3;
			pys_s4 <= cy3 * s_s3;
			pxs_s4 <= cx3 * s_s3;
			pyc_s4 <= cy3 * c_s3;
			c2k_s4 <= NW'(c_s3) <<< 11;
			s2k_s4 <= NW'(s_s3) <<< 11;
			sx_s4  <= view_s3.sx;
			sy_s4  <= view_s3.sy;
		end
	end

	// s5: numerators and denominators
	logic signed [NW-1:0] num_s5 [0:LANES-1];
	logic signed [DW:0]   den_s5 [0:LANES-1];
	logic signed [DW:0]   sxe, sye;

	always_comb begin
		sxe = (DW+1)'(sx_s4);
		sye = (DW+1)'(sy_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5[0] <= c2k_s4;
			num_s5[1] <= s2k_s4;
			num_s5[2] <= 0 - pxc_s4 - pys_s4;
			num_s5[3] <= s2k_s4;
			num_s5[4] <= 0 - c2k_s4;
			num_s5[5] <= pyc_s4 - pxs_s4;
			den_s5[0] <= sxe;
			den_s5[1] <= sxe;
			den_s5[2] <= sxe <<< 5;
			den_s5[3] <= sye;
			den_s5[4] <= sye;
			den_s5[5] <= sye <<< 5;
		end
	end

	// s6: magnitudes, s7: rounding bias, s8: overflow check and remainder seed
	logic [NW-1:0] un_s6 [0:LANES-1];
	logic [DW-1:0] ud_s6 [0:LANES-1];
	logic          negr_s6 [0:LANES-1];
	logic [NW-1:0] n_s7 [0:LANES-1];
	logic [DW-1:0] ud_s7 [0:LANES-1];
	logic          negr_s7 [0:LANES-1];
	div_lane_t     dv [0:LANES-1][0:QW];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		div_lane_t lane_s8;
		logic      hi_ovf;

		always_ff @(posedge clk) begin
			if (adv) begin
				un_s6[l]   <= num_s5[l][NW-1] ? NW'(-num_s5[l]) : NW'(num_s5[l]);
				ud_s6[l]   <= den_s5[l][DW] ? DW'(-den_s5[l]) : DW'(den_s5[l]);
				negr_s6[l] <= num_s5[l][NW-1] ^ den_s5[l][DW];
				n_s7[l]    <= un_s6[l] + NW'(ud_s6[l] >> 1);
				ud_s7[l]   <= ud_s6[l];
				negr_s7[l] <= negr_s6[l];
			end
		end

		assign hi_ovf = ({{(DW-HW){1'b0}}, n_s7[l][NW-1:QW]} >= ud_s7[l]);

		always_ff @(posedge clk) begin
			if (adv) begin
				lane_s8.r    <= hi_ovf ? '0 : {{(DW-HW){1'b0}}, n_s7[l][NW-1:QW]};
				lane_s8.nq   <= n_s7[l][QW-1:0];
				lane_s8.d    <= ud_s7[l];
				lane_s8.negr <= negr_s7[l];
				lane_s8.ovf  <= hi_ovf;
			end
		end

		assign dv[l][0] = lane_s8;

		for (genvar j = 0; j < QW; j++) begin : g_div
			vtm_div_cell u_cell (
				.clk  (clk),
				.en   (adv),
				.din  (dv[l][j]),
				.dout (dv[l][j+1])
			);
		end
	end

	// output register: rounding sign, saturation, status
	logic [QW-1:0] m_nxt [0:LANES-1];
	logic [QW-1:0] m_q   [0:LANES-1];
	logic          any_sat;
	status_t       st_nxt, status_q;

	always_comb begin
		logic [QW-1:0] q;
		logic          sp, sn;
		any_sat = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			q  = dv[l][QW].nq;
			sp = !dv[l][QW].negr && (dv[l][QW].ovf || q[QW-1]);
			sn = dv[l][QW].negr && (dv[l][QW].ovf || (q[QW-1] && (q[QW-2:0] != '0)));
			if (zf_q[LAT-2]) begin
				m_nxt[l] = '0;
			end else if (sp) begin
				m_nxt[l] = OUT_MAX;
			end else if (sn) begin
				m_nxt[l] = OUT_MIN;
			end else begin
				m_nxt[l] = dv[l][QW].negr ? (~q + 1'b1) : q;
			end
			any_sat = any_sat || sp || sn;
		end
		if (zf_q[LAT-2]) begin
			st_nxt = ST_ZERO;
		end else if (any_sat) begin
			st_nxt = ST_SAT;
		end else begin
			st_nxt = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				m_q[l] <= m_nxt[l];
			end
			status_q <= st_nxt;
		end
	end

	assign m_tdata = {m_q[5], m_q[4], m_q[3], m_q[2], m_q[1], m_q[0]};
	assign m_tuser = status_q;

endmodule
`default_nettype wire

// ===== test/view_transform_matrix_gen_tb.sv =====
// Testbench for view_transform_matrix_gen: drives camera views on the input stream and
// checks each matrix and status against a behavioral predictor. Depends on vtm_pkg.
`default_nettype none
module view_transform_matrix_gen_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vtm_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN = 150;

	typedef struct packed {
		logic [1:0]  status;
		logic [39:0] m12;
		logic [39:0] m11;
		logic [39:0] m10;
		logic [39:0] m02;
		logic [39:0] m01;
		logic [39:0] m00;
	} matrix_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [239:0] m_tdata;
	logic [1:0]   m_tuser;

	matrix_t matrix_q[$];
	int      mismatches;
	int      idle_cycles;
	int      send_idle_pct;
	int      recv_idle_pct;
	bit      timed_out;

	view_transform_matrix_gen i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint rdiv_sat(longint num, longint den, inout bit sat);
		longint unsigned un, ud, q;
		bit negr;
		un = num < 0 ? 64'd0 - 64'(num) : 64'(num);
		ud = den < 0 ? 64'd0 - 64'(den) : 64'(den);
		negr = (num < 0) != (den < 0);
		q = (un + ud / 2) / ud;
		if (!negr && q > 64'd549755813887) begin
			sat = 1'b1;
			return 64'sd549755813887;
		end
		if (negr && q > 64'd549755813888) begin
			sat = 1'b1;
			return -64'sd549755813888;
		end
		return negr ? -longint'(q) : longint'(q);
	endfunction

	function automatic matrix_t predict_matrix(logic [159:0] view);
		matrix_t r;
		longint cx, cy, sx, sy, ang, red, x, y, z, dx, dy, c, s;
		longint m[6];
		bit neg, sat;
		cx = longint'($signed(view[31:0]));
		cy = longint'($signed(view[63:32]));
		sx = longint'($signed(view[95:64]));
		sy = longint'($signed(view[127:96]));
		ang = longint'($signed(view[159:128]));
		r = '0;
		if (sx == 0 || sy == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		red = ang % 64'sd1686629713;
		if (red < 0)
			red += 64'sd1686629713;
		if (red > 64'sd843314857)
			red -= 64'sd1686629713;
		neg = 1'b0;
		if (red > 64'sd421657428) begin
			red -= 64'sd843314857;
			neg = 1'b1;
		end else if (red < -64'sd421657428) begin
			red += 64'sd843314857;
			neg = 1'b1;
		end
		z = red * 4;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < (CORDIC_STAGES > 32 ? 32 : CORDIC_STAGES); i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
		sat = 1'b0;
		m[0] = rdiv_sat(c * 2048, sx, sat);
		m[1] = rdiv_sat(s * 2048, sx, sat);
		m[2] = rdiv_sat(-(cx * c + cy * s), sx * 32, sat);
		m[3] = rdiv_sat(s * 2048, sy, sat);
		m[4] = rdiv_sat(-(c * 2048), sy, sat);
		m[5] = rdiv_sat(-(cx * s - cy * c), sy * 32, sat);
		r.m00 = m[0][39:0];
		r.m01 = m[1][39:0];
		r.m02 = m[2][39:0];
		r.m10 = m[3][39:0];
		r.m11 = m[4][39:0];
		r.m12 = m[5][39:0];
		r.status = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	task automatic send_view(logic [31:0] cx, logic [31:0] cy, logic [31:0] ex,
			logic [31:0] ey, logic [31:0] ang);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ang, ey, ex, cy, cx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		matrix_q.push_back(predict_matrix({ang, ey, ex, cy, cx}));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(3) - 1;
			3: return 32'($signed(16'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_extent();
		if ($urandom_range(19) == 0)
			return 32'h0;
		if ($urandom_range(3) == 0)
			return rand_word();
		return $urandom_range(1) ? 32'($urandom_range(32'h0100_0000, 32'h100))
			: -32'($urandom_range(32'h0100_0000, 32'h100));
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (matrix_q.size() != 0 && !timed_out)
			@(negedge clk);
	endtask

	task automatic test_directed();
		logic [31:0] angs[9];
		angs = '{32'h0, 32'd421657428, 32'd421657429, 32'd843314857, 32'd843314858,
			-32'd421657429, 32'h7fff_ffff, 32'h8000_0000, 32'd1686629713};
		foreach (angs[i])
			send_view(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0001_8000, angs[i]);
		send_view(32'h1234_5678, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
		send_view(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h1000_0000);
		send_view(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_view(32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h1, 32'h0);
		send_view(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0800_0000);
		send_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_view(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_view(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h1, 32'hffff_ffff);
		send_view(32'h0, 32'h0, 32'h0000_0800, 32'h0000_0800, 32'h0);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_view(rand_word(), rand_word(), rand_extent(), rand_extent(), rand_word());
	endtask

	task automatic test_pause_drain();
		test_random(20);
		wait_drained();
		test_random(20);
	endtask

	always @(negedge clk)
		m_tready <= arst_n && $urandom_range(99) >= recv_idle_pct;

	always @(posedge clk) begin
		matrix_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata};
			if (matrix_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %h", got);
			end else begin
				want = matrix_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d %h %h %h %h %h %h got st=%0d %h %h %h %h %h %h",
							want.status, want.m00, want.m01, want.m02, want.m10, want.m11,
							want.m12, got.status, got.m00, got.m01, got.m02, got.m10,
							got.m11, got.m12);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("view_transform_matrix_gen_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 29;
		recv_idle_pct = 47;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(260);
		send_idle_pct = 47;
		recv_idle_pct = 29;
		test_pause_drain();
		test_random(240);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(280);
		wait_drained();
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0 && matrix_q.size() == 0)
			$display("view_transform_matrix_gen_tb OK");
		else
			$display("view_transform_matrix_gen_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
